/* hdl/gctt_pkg.sv */
// ----------------------------------------------------------------------------
// gctt_pkg
// Shared types and constants for the colour gradient tab table.
// ----------------------------------------------------------------------------
package gctt_pkg;

  localparam int unsigned NumPositionsDefault = 256;
  localparam int unsigned ChanW = 8;
  localparam int unsigned ColourW = 32;
  localparam logic [ColourW-1:0] FirstColour = 32'h0000_00FF;
  localparam logic [ColourW-1:0] LastColour = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_DELETE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_POS,
    ST_RD_TGT,
    ST_MV_CLR,
    ST_SCAN_LO,
    ST_SCAN_HI,
    ST_CHAN,
    ST_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] position;
    logic [7:0] target_position;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [7:0] result_position;
    logic       status;
  } rsp_t;

  typedef struct packed {
    logic               present;
    logic [ColourW-1:0] colour;
  } entry_t;

endpackage

/* hdl/colour_gradient_tab_table_core.sv */
// ----------------------------------------------------------------------------
// colour_gradient_tab_table_core
// Gradient of RGBA tabs with set, delete, move and interpolating lookup.
// ----------------------------------------------------------------------------
// Requests enter on in_req_i under in_valid_i/in_ready_o; each gives exactly
// one response on out_rsp_o under out_valid_o/out_ready_i.
// Tabs and their presence live in one memory with one read and one write
// port and a registered read.
// After reset a clearing pass writes every entry (endpoints black/opaque
// and white); in_ready_o stays low until it ends.
// Set, delete and lookup hit read the position and respond; move also reads
// the target and, if it is free or an end, writes it and clears the source.
// A lookup between tabs scans down to the lower tab and up to the upper
// tab, then runs four channels through the shared divider, each with a
// start, eight divide steps and a done strobe.
// in_ready_o returns in the cycle after the response is registered.
// The block works on one request at a time. The response is held in an
// output register; a stalled receiver holds the next response back, while
// the next request may already be accepted and processed.
// ----------------------------------------------------------------------------
module colour_gradient_tab_table_core #(
  parameter int unsigned NUM_POSITIONS = gctt_pkg::NumPositionsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gctt_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gctt_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned PW = $clog2(NUM_POSITIONS);
  localparam int unsigned AW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] Last = PW'(NUM_POSITIONS - 1);

  gctt_pkg::entry_t mem_q [NUM_POSITIONS];
  gctt_pkg::entry_t rdata_q;
  gctt_pkg::entry_t wdata;
  logic             we;
  logic [PW-1:0]    wa;
  logic [PW-1:0]    ra;

  gctt_pkg::state_e state_q, state_d;
  gctt_pkg::rsp_t   out_q;
  logic             out_valid_q;

  logic [1:0]       op_q;
  logic [PW-1:0]    pos_q, tgt_q, lo_q, hi_q, gap_q, d_q, clr_q;
  logic [31:0]      in_col_q, src_col_q, lo_col_q, hi_col_q;
  logic [3:0][7:0]  res_col_q;
  logic             res_st_q;
  logic [7:0]       res_pos_q;
  logic [1:0]       ch_q;

  logic [PW-1:0]    in_pos, in_tgt;
  logic             pos_end, tgt_end;
  logic             div_start, div_done;
  logic [7:0]       div_a, div_b, div_q;

  function automatic logic [PW-1:0] clamp(input logic [7:0] p);
    logic [AW-1:0] e;
    e = AW'(p);
    return (e > AW'(Last)) ? Last : PW'(e);
  endfunction

  assign in_pos  = clamp(in_req_i.position);
  assign in_tgt  = clamp(in_req_i.target_position);
  assign pos_end = (pos_q == '0) || (pos_q == Last);
  assign tgt_end = (tgt_q == '0) || (tgt_q == Last);
  assign in_ready_o = (state_q == gctt_pkg::ST_IDLE);

  assign div_a = lo_col_q[31 - 8*ch_q -: 8];
  assign div_b = hi_col_q[31 - 8*ch_q -: 8];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wdata;
    end
    rdata_q <= mem_q[ra];
  end

  always_comb begin
    state_d   = state_q;
    we        = 1'b0;
    wa        = pos_q;
    wdata     = rdata_q;
    ra        = in_pos;
    div_start = 1'b0;
    unique case (state_q)
      gctt_pkg::ST_INIT: begin
        we    = 1'b1;
        wa    = clr_q;
        wdata = '0;
        if (clr_q == '0) begin
          wdata = {1'b1, gctt_pkg::FirstColour};
        end else if (clr_q == Last) begin
          wdata   = {1'b1, gctt_pkg::LastColour};
          state_d = gctt_pkg::ST_IDLE;
        end
      end
      gctt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gctt_pkg::ST_RD_POS;
        end
      end
      gctt_pkg::ST_RD_POS: begin
        ra      = tgt_q;
        state_d = gctt_pkg::ST_RESP;
        unique case (op_q)
          gctt_pkg::OP_SET: begin
            we    = 1'b1;
            wdata = {1'b1, in_col_q};
          end
          gctt_pkg::OP_DELETE: begin
            if (!pos_end && rdata_q.present) begin
              we            = 1'b1;
              wdata.present = 1'b0;
            end
          end
          gctt_pkg::OP_MOVE: begin
            if (rdata_q.present && pos_q != tgt_q) begin
              state_d = gctt_pkg::ST_RD_TGT;
            end
          end
          default: begin
            if (!rdata_q.present) begin
              ra      = pos_q - PW'(1);
              state_d = gctt_pkg::ST_SCAN_LO;
            end
          end
        endcase
      end
      gctt_pkg::ST_RD_TGT: begin
        state_d = gctt_pkg::ST_RESP;
        if (!rdata_q.present || tgt_end) begin
          we      = 1'b1;
          wa      = tgt_q;
          wdata   = {1'b1, src_col_q};
          state_d = gctt_pkg::ST_MV_CLR;
        end
      end
      gctt_pkg::ST_MV_CLR: begin
        we      = !pos_end;
        wdata   = {1'b0, src_col_q};
        state_d = gctt_pkg::ST_RESP;
      end
      gctt_pkg::ST_SCAN_LO: begin
        if (rdata_q.present) begin
          ra      = hi_q;
          state_d = gctt_pkg::ST_SCAN_HI;
        end else begin
          ra = lo_q - PW'(1);
        end
      end
      gctt_pkg::ST_SCAN_HI: begin
        ra = hi_q + PW'(1);
        if (rdata_q.present) begin
          state_d = gctt_pkg::ST_CHAN;
        end
      end
      gctt_pkg::ST_CHAN: begin
        div_start = 1'b1;
        state_d   = gctt_pkg::ST_WAIT;
      end
      gctt_pkg::ST_WAIT: begin
        if (div_done) begin
          state_d = (ch_q == 2'd3) ? gctt_pkg::ST_RESP : gctt_pkg::ST_CHAN;
        end
      end
      gctt_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = gctt_pkg::ST_IDLE;
        end
      end
      default: state_d = gctt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gctt_pkg::ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gctt_pkg::ST_INIT) begin
        clr_q <= clr_q + PW'(1);
      end
      if (state_q == gctt_pkg::ST_RESP && state_d == gctt_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gctt_pkg::ST_IDLE: begin
        op_q      <= in_req_i.opcode;
        pos_q     <= in_pos;
        tgt_q     <= in_tgt;
        in_col_q  <= {in_req_i.red_in, in_req_i.green_in,
                      in_req_i.blue_in, in_req_i.alpha_in};
        res_col_q <= '0;
        res_st_q  <= 1'b0;
        res_pos_q <= 8'(in_pos);
      end
      gctt_pkg::ST_RD_POS: begin
        src_col_q <= rdata_q.colour;
        lo_q      <= pos_q - PW'(1);
        hi_q      <= pos_q + PW'(1);
        unique case (op_q)
          gctt_pkg::OP_SET: res_st_q <= 1'b0;
          gctt_pkg::OP_DELETE: res_st_q <= pos_end || !rdata_q.present;
          gctt_pkg::OP_MOVE: res_st_q <= !rdata_q.present || pos_q == tgt_q;
          default: begin
            if (rdata_q.present) begin
              res_col_q <= rdata_q.colour;
            end
          end
        endcase
      end
      gctt_pkg::ST_RD_TGT: begin
        if (!rdata_q.present || tgt_end) begin
          res_pos_q <= 8'(tgt_q);
        end else begin
          res_st_q <= 1'b1;
        end
      end
      gctt_pkg::ST_SCAN_LO: begin
        if (rdata_q.present) begin
          lo_col_q <= rdata_q.colour;
        end else begin
          lo_q <= lo_q - PW'(1);
        end
      end
      gctt_pkg::ST_SCAN_HI: begin
        if (rdata_q.present) begin
          hi_col_q <= rdata_q.colour;
          gap_q    <= hi_q - lo_q;
          d_q      <= pos_q - lo_q;
          ch_q     <= '0;
        end else begin
          hi_q <= hi_q + PW'(1);
        end
      end
      gctt_pkg::ST_WAIT: begin
        if (div_done) begin
          res_col_q[2'd3 - ch_q] <= div_q;
          ch_q                   <= ch_q + 2'd1;
        end
      end
      gctt_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= {res_col_q, res_pos_q, res_st_q};
        end
      end
      default: ;
    endcase
  end

  gctt_div #(
    .PW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .gap_i   (gap_q),
    .d_i     (d_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* hdl/gctt_div.sv */
// ----------------------------------------------------------------------------
// gctt_div
// Interpolates one channel: floor((a*(gap-d) + b*d) / gap), one quotient bit
// per cycle after a multiply cycle.
// ----------------------------------------------------------------------------
module gctt_div #(
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [7:0]    a_i,
  input  logic [7:0]    b_i,
  input  logic [PW-1:0] gap_i,
  input  logic [PW-1:0] d_i,
  output logic          done_o,
  output logic [7:0]    quot_o
);

  localparam int unsigned NW = 8 + PW;

  logic          busy_q;
  logic          done_q;
  logic [2:0]    step_q;
  logic [NW-1:0] num_q;
  logic [7:0]    quot_q;
  logic [NW-1:0] dsh;

  // quotient never exceeds 255, so eight restoring steps suffice
  assign dsh = NW'(gap_i) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
      end else if (busy_q) begin
        step_q <= step_q - 3'd1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= NW'(a_i) * NW'(gap_i - d_i) + NW'(b_i) * NW'(d_i);
      quot_q <= '0;
    end else if (busy_q) begin
      if (num_q >= dsh) begin
        num_q          <= num_q - dsh;
        quot_q[step_q] <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
